[rtl/core/ffsp_pkg.sv]
// Shared types and constants for the first-fit slotted page store.
package ffsp_pkg;

  localparam logic [1:0] FUNC_INSERT  = 2'd0;
  localparam logic [1:0] FUNC_SEARCH  = 2'd1;
  localparam logic [1:0] FUNC_DISPLAY = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  localparam int unsigned MAX_PAGES    = 16;
  localparam int unsigned MAX_RECORDS  = 256;
  localparam int unsigned HEADER_BYTES = 16;
  localparam int unsigned SLOT_BYTES   = 4;
  localparam logic [15:0] SLOT_MAX     = 16'hFFFF;
  localparam int unsigned DISPLAY_MAX  = 16;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PAGE,
    S_PAGE_WAIT,
    S_FIT,
    S_SCAN_REQ,
    S_SCAN_CHK,
    S_COMMIT,
    S_NEWPAGE,
    S_DISP_HEAD,
    S_DISP_REQ,
    S_DISP_OUT,
    S_DONE
  } state_t;

endpackage

[rtl/core/ffsp_entry_mem.sv]
// Record entry memory: key, length, page and slot per stored record.
module ffsp_entry_mem #(
  parameter int unsigned AW = 8,
  parameter int unsigned PW = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wkey,
  input  logic [15:0]   wlen,
  input  logic [PW-1:0] wpage,
  input  logic [15:0]   wslot,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rkey,
  output logic [15:0]   rlen,
  output logic [PW-1:0] rpage,
  output logic [15:0]   rslot
);

  localparam int unsigned DEPTH = 1 << AW;

  logic [31:0]   key_mem  [DEPTH];
  logic [15:0]   len_mem  [DEPTH];
  logic [PW-1:0] page_mem [DEPTH];
  logic [15:0]   slot_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr]  <= wkey;
      len_mem[waddr]  <= wlen;
      page_mem[waddr] <= wpage;
      slot_mem[waddr] <= wslot;
    end
    rkey  <= key_mem[raddr];
    rlen  <= len_mem[raddr];
    rpage <= page_mem[raddr];
    rslot <= slot_mem[raddr];
  end

endmodule

[rtl/core/ffsp_page_mem.sv]
// Page table memory: used bytes, top slot and record count per page.
module ffsp_page_mem #(
  parameter int unsigned PW = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [PW-1:0] waddr,
  input  logic [31:0]   wused,
  input  logic [15:0]   wtop,
  input  logic [8:0]    wcnt,
  input  logic [PW-1:0] raddr,
  output logic [31:0]   rused,
  output logic [15:0]   rtop,
  output logic [8:0]    rcnt
);

  localparam int unsigned DEPTH = 1 << PW;

  logic [31:0] used_mem [DEPTH];
  logic [15:0] top_mem  [DEPTH];
  logic [8:0]  cnt_mem  [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      used_mem[waddr] <= wused;
      top_mem[waddr]  <= wtop;
      cnt_mem[waddr]  <= wcnt;
    end
    rused <= used_mem[raddr];
    rtop  <= top_mem[raddr];
    rcnt  <= cnt_mem[raddr];
  end

endmodule

[rtl/core/first_fit_slotted_page_store_top.sv]
// Top level of the first-fit slotted page store with its sequencer.
// A request walks the pages in order: a page-table read and fit check per page, then on
// a page that fits or is searched a scan that reads and compares each stored record, then
// the result. A display gives a header result and then one result per page, up to 16 pages.
// One request at a time, busy high until the last result; no receiver stall.
// Reset (rst, synchronous) empties the store and sets page_bytes to 4096.
module first_fit_slotted_page_store_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         func,
  input  logic signed [31:0] record_key,
  input  logic [15:0]        record_bytes,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data,
  output logic               result_valid,
  output logic [1:0]         status,
  output logic [3:0]         page_index,
  output logic [15:0]        slot_index,
  output logic [8:0]         count,
  output logic               last
);

  // Index widths follow the table depths; counters get one more bit so that
  // they can hold the full depth.
  localparam int unsigned PW  = (ffsp_pkg::MAX_PAGES > 1) ? $clog2(ffsp_pkg::MAX_PAGES) : 1;
  localparam int unsigned RW  = (ffsp_pkg::MAX_RECORDS > 1) ?
                                $clog2(ffsp_pkg::MAX_RECORDS) : 1;
  localparam int unsigned PCW = $clog2(ffsp_pkg::MAX_PAGES + 1);
  localparam int unsigned RCW = $clog2(ffsp_pkg::MAX_RECORDS + 1);
  localparam int unsigned NDISP = (ffsp_pkg::MAX_PAGES < ffsp_pkg::DISPLAY_MAX) ?
                                  ffsp_pkg::MAX_PAGES : ffsp_pkg::DISPLAY_MAX;

  ffsp_pkg::state_t state, state_next;

  logic [15:0]       page_bytes;
  logic [PCW-1:0]    pages_in_use;
  logic [RCW-1:0]    records_in_use;
  logic [1:0]        op;
  logic [31:0]       key;
  logic [15:0]       size;
  logic [PCW-1:0]    page;       // page under inspection
  logic [RCW-1:0]    rec;        // record under inspection
  logic              hit;
  logic [RW-1:0]     hit_rec;
  logic [15:0]       hit_len;
  logic [15:0]       hit_slot;

  logic [31:0]       pg_rused;
  logic [15:0]       pg_rtop;
  logic [8:0]        pg_rcnt;
  logic              pg_we;
  logic [31:0]       pg_wused;
  logic [15:0]       pg_wtop;
  logic [8:0]        pg_wcnt;

  logic [31:0]       en_rkey;
  logic [15:0]       en_rlen;
  logic [PW-1:0]     en_rpage;
  logic [15:0]       en_rslot;
  logic              en_we;
  logic [RW-1:0]     en_waddr;
  logic [RW-1:0]     en_raddr;
  logic [15:0]       en_wslot;

  logic [15:0]       new_slot;
  logic              fits;
  logic [33:0]       avail;

  assign cfg_ready = (state == ffsp_pkg::S_IDLE);
  assign busy      = (state != ffsp_pkg::S_IDLE);

  ffsp_page_mem #(.PW(PW)) u_page (
    .clk(clk), .we(pg_we), .waddr(page[PW-1:0]), .wused(pg_wused), .wtop(pg_wtop),
    .wcnt(pg_wcnt), .raddr(page[PW-1:0]), .rused(pg_rused), .rtop(pg_rtop),
    .rcnt(pg_rcnt)
  );

  ffsp_entry_mem #(.AW(RW), .PW(PW)) u_entry (
    .clk(clk), .we(en_we), .waddr(en_waddr), .wkey(key), .wlen(size),
    .wpage(page[PW-1:0]), .wslot(en_wslot), .raddr(en_raddr), .rkey(en_rkey),
    .rlen(en_rlen), .rpage(en_rpage), .rslot(en_rslot)
  );

  // The single shared compare: free space of the page against size+4.
  assign avail    = {2'b00, 16'd0, page_bytes} - {2'b00, pg_rused};
  assign fits     = !avail[33] && (avail >= {18'd0, size} + 34'(ffsp_pkg::SLOT_BYTES));
  assign new_slot = (pg_rtop == ffsp_pkg::SLOT_MAX) ? ffsp_pkg::SLOT_MAX : pg_rtop + 16'd1;
  assign en_raddr = rec[RW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ffsp_pkg::S_IDLE;
      page_bytes     <= 16'd4096;
      pages_in_use   <= '0;
      records_in_use <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        page_bytes <= cfg_data;
      end
      if (state == ffsp_pkg::S_COMMIT && en_we && !hit) begin
        records_in_use <= records_in_use + RCW'(1);
      end
      if (state == ffsp_pkg::S_NEWPAGE) begin
        records_in_use <= records_in_use + RCW'(1);
        pages_in_use   <= pages_in_use + PCW'(1);
      end
    end
  end

  // Datapath registers that need no reset.
  always_ff @(posedge clk) begin
    unique case (state)
      ffsp_pkg::S_IDLE: begin
        op   <= func;
        key  <= record_key;
        size <= record_bytes;
        page <= '0;
      end
      ffsp_pkg::S_FIT: begin
        rec <= '0;
        hit <= 1'b0;
      end
      ffsp_pkg::S_SCAN_CHK: begin
        if (!hit && en_rpage == page[PW-1:0] && en_rkey == key) begin
          hit      <= 1'b1;
          hit_rec  <= rec[RW-1:0];
          hit_len  <= en_rlen;
          hit_slot <= en_rslot;
        end
        rec <= rec + RCW'(1);
      end
      ffsp_pkg::S_DISP_OUT: page <= page + PCW'(1);
      default: begin
      end
    endcase
    if (state == ffsp_pkg::S_SCAN_REQ && op == ffsp_pkg::FUNC_SEARCH && hit) begin
      page <= page;
    end else if (state_next == ffsp_pkg::S_PAGE && state != ffsp_pkg::S_IDLE) begin
      page <= page + PCW'(1);
    end
  end

  always_comb begin
    state_next   = state;
    pg_we        = 1'b0;
    pg_wused     = pg_rused;
    pg_wtop      = new_slot;
    pg_wcnt      = pg_rcnt;
    en_we        = 1'b0;
    en_waddr     = records_in_use[RW-1:0];
    en_wslot     = new_slot;
    result_valid = 1'b0;
    status       = ffsp_pkg::ST_OK;
    page_index   = 4'd0;
    slot_index   = 16'd0;
    count        = 9'd0;
    last         = 1'b0;
    unique case (state)
      ffsp_pkg::S_IDLE: begin
        if (start) begin
          unique case (func)
            ffsp_pkg::FUNC_INSERT, ffsp_pkg::FUNC_SEARCH: state_next = ffsp_pkg::S_PAGE;
            ffsp_pkg::FUNC_DISPLAY: state_next = ffsp_pkg::S_DISP_HEAD;
            default: state_next = ffsp_pkg::S_IDLE;
          endcase
        end
      end
      ffsp_pkg::S_PAGE: begin
        if (page >= pages_in_use) begin
          if (op == ffsp_pkg::FUNC_SEARCH) begin
            result_valid = 1'b1;
            status       = ffsp_pkg::ST_NOTFOUND;
            last         = 1'b1;
            state_next   = ffsp_pkg::S_IDLE;
          end else if (pages_in_use >= PCW'(ffsp_pkg::MAX_PAGES) ||
                       records_in_use >= RCW'(ffsp_pkg::MAX_RECORDS)) begin
            result_valid = 1'b1;
            status       = ffsp_pkg::ST_FULL;
            last         = 1'b1;
            state_next   = ffsp_pkg::S_IDLE;
          end else begin
            state_next = ffsp_pkg::S_NEWPAGE;
          end
        end else begin
          state_next = ffsp_pkg::S_PAGE_WAIT;
        end
      end
      ffsp_pkg::S_PAGE_WAIT: state_next = ffsp_pkg::S_FIT;
      ffsp_pkg::S_FIT: begin
        if (op == ffsp_pkg::FUNC_SEARCH || fits) begin
          state_next = ffsp_pkg::S_SCAN_REQ;
        end else begin
          state_next = ffsp_pkg::S_PAGE;
        end
      end
      ffsp_pkg::S_SCAN_REQ: begin
        if (hit || rec >= records_in_use) begin
          if (op == ffsp_pkg::FUNC_SEARCH) begin
            state_next = hit ? ffsp_pkg::S_DONE : ffsp_pkg::S_PAGE;
          end else begin
            state_next = ffsp_pkg::S_COMMIT;
          end
        end else begin
          state_next = ffsp_pkg::S_SCAN_CHK;
        end
      end
      ffsp_pkg::S_SCAN_CHK: state_next = ffsp_pkg::S_SCAN_REQ;
      ffsp_pkg::S_DONE: begin
        // Report the slot that was captured together with the hit.
        result_valid = 1'b1;
        page_index   = 4'(page);
        slot_index   = hit_slot;
        last         = 1'b1;
        state_next   = ffsp_pkg::S_IDLE;
      end
      ffsp_pkg::S_COMMIT: begin
        result_valid = 1'b1;
        last         = 1'b1;
        state_next   = ffsp_pkg::S_IDLE;
        if (!hit && records_in_use >= RCW'(ffsp_pkg::MAX_RECORDS)) begin
          status = ffsp_pkg::ST_FULL;
        end else begin
          page_index = 4'(page);
          slot_index = new_slot;
          pg_we      = 1'b1;
          en_we      = 1'b1;
          if (hit) begin
            en_waddr = hit_rec;
            pg_wused = pg_rused - {16'd0, hit_len} + {16'd0, size};
          end else begin
            pg_wcnt  = pg_rcnt + 9'd1;
            pg_wused = pg_rused + {16'd0, size} + 32'(ffsp_pkg::SLOT_BYTES);
          end
        end
      end
      ffsp_pkg::S_NEWPAGE: begin
        result_valid = 1'b1;
        page_index   = 4'(page);
        last         = 1'b1;
        pg_we        = 1'b1;
        en_we        = 1'b1;
        en_wslot     = 16'd0;
        pg_wtop      = 16'd0;
        pg_wcnt      = 9'd1;
        pg_wused     = {16'd0, size} + 32'(ffsp_pkg::HEADER_BYTES + ffsp_pkg::SLOT_BYTES);
        state_next   = ffsp_pkg::S_IDLE;
      end
      ffsp_pkg::S_DISP_HEAD: begin
        result_valid = 1'b1;
        count        = 9'(pages_in_use);
        last         = (pages_in_use == '0);
        state_next   = (pages_in_use == '0) ? ffsp_pkg::S_IDLE : ffsp_pkg::S_DISP_REQ;
      end
      ffsp_pkg::S_DISP_REQ: state_next = ffsp_pkg::S_DISP_OUT;
      ffsp_pkg::S_DISP_OUT: begin
        result_valid = 1'b1;
        page_index   = 4'(page);
        count        = pg_rcnt;
        if (page + PCW'(1) >= pages_in_use || 32'(page) + 32'd1 >= 32'(NDISP)) begin
          last       = 1'b1;
          state_next = ffsp_pkg::S_IDLE;
        end else begin
          state_next = ffsp_pkg::S_DISP_REQ;
        end
      end
      default: state_next = ffsp_pkg::S_IDLE;
    endcase
  end

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the first-fit slotted page store.
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  // The selector value that the block is expected to ignore.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int NUM_PAGES   = ffsp_pkg::MAX_PAGES;
  localparam int NUM_RECORDS = ffsp_pkg::MAX_RECORDS;
  // Cycles without any accepted request, result or register write before
  // the run is declared hung. The slowest request is a missing search over
  // every page and every stored record, and this limit leaves a wide margin
  // above it.
  localparam int HANG_LIMIT = 60000;
  // Cycles to let pass after the last result before touching the register,
  // since an ignored request produces no result to wait for.
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  page_index;
    logic [15:0] slot_index;
    logic [8:0]  count;
    logic        last;
  } page_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         func = ffsp_pkg::FUNC_INSERT;
  logic signed [31:0] record_key = '0;
  logic [15:0]        record_bytes = '0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [15:0]        cfg_data = '0;
  logic               result_valid;
  logic [1:0]         status;
  logic [3:0]         page_index;
  logic [15:0]        slot_index;
  logic [8:0]         count;
  logic               last;

  first_fit_slotted_page_store_top dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .func        (func),
    .record_key  (record_key),
    .record_bytes(record_bytes),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .result_valid(result_valid),
    .status      (status),
    .page_index  (page_index),
    .slot_index  (slot_index),
    .count       (count),
    .last        (last)
  );

  always #10 clk = ~clk;

  // Shadow copy of the store. Byte counts are kept wide so that oversized
  // records and the replace arithmetic behave exactly as 32-bit unsigned.
  int unsigned   page_bytes_q;
  int unsigned   pages_used;
  int unsigned   records_used;
  int unsigned   pg_used_bytes [NUM_PAGES];
  int unsigned   pg_top_slot   [NUM_PAGES];
  int unsigned   pg_rec_count  [NUM_PAGES];
  logic [31:0]   rec_key       [NUM_RECORDS];
  int unsigned   rec_len       [NUM_RECORDS];
  int unsigned   rec_page      [NUM_RECORDS];
  int unsigned   rec_slot      [NUM_RECORDS];

  // Results still owed by the block, oldest first.
  page_result_t pending_results[$];
  page_result_t got;
  page_result_t want;
  int           fail_count = 0;
  int           quiet_cycles = 0;
  // When set, the request side never idles between requests.
  bit           no_gaps = 1'b0;
  logic [31:0]  key_pool [24];

  function automatic page_result_t make_result(logic [1:0] st, int unsigned pg,
                                               int unsigned sl, int unsigned cnt,
                                               bit lst);
    page_result_t r;
    r.status     = st;
    r.page_index = pg[3:0];
    r.slot_index = sl[15:0];
    r.count      = cnt[8:0];
    r.last       = lst;
    return r;
  endfunction

  // Appends one expected result behind those already owed.
  task automatic expect_result(page_result_t r);
    begin
      pending_results = {pending_results, r};
    end
  endtask

  // Index of the record holding key in page pg, or -1 when it is absent.
  function automatic int find_record(int unsigned pg, logic [31:0] key);
    for (int i = 0; i < records_used; i++)
      if (rec_page[i] == pg && rec_key[i] == key) return i;
    return -1;
  endfunction

  task automatic predict_insert(logic [31:0] key, int unsigned size);
    longint      avail;
    int          e;
    int unsigned slot;
    begin
      for (int unsigned p = 0; p < pages_used; p++) begin
        avail = longint'(page_bytes_q) - longint'(pg_used_bytes[p]);
        if (avail >= longint'(size) + longint'(ffsp_pkg::SLOT_BYTES)) begin
          e = find_record(p, key);
          slot = (pg_top_slot[p] >= ffsp_pkg::SLOT_MAX) ? ffsp_pkg::SLOT_MAX
                                                        : pg_top_slot[p] + 1;
          if (e < 0) begin
            // A full record table stops the insert here; later pages are
            // not tried.
            if (records_used >= NUM_RECORDS) begin
              expect_result(make_result(ffsp_pkg::ST_FULL, 0, 0, 0, 1'b1));
              return;
            end
            e = records_used;
            records_used++;
            rec_key[e] = key;
            rec_page[e] = p;
            pg_rec_count[p]++;
            pg_used_bytes[p] += size + ffsp_pkg::SLOT_BYTES;
          end else begin
            // Replacing a key in place swaps its length and slot only.
            pg_used_bytes[p] = pg_used_bytes[p] - rec_len[e] + size;
          end
          rec_len[e] = size;
          rec_slot[e] = slot;
          pg_top_slot[p] = slot;
          expect_result(make_result(ffsp_pkg::ST_OK, p, slot, 0, 1'b1));
          return;
        end
      end
      if (pages_used >= NUM_PAGES || records_used >= NUM_RECORDS) begin
        expect_result(make_result(ffsp_pkg::ST_FULL, 0, 0, 0, 1'b1));
        return;
      end
      // No page fits, so a fresh page opens with the record in slot 0, even
      // when the record is larger than the page.
      pg_used_bytes[pages_used] = ffsp_pkg::HEADER_BYTES + size + ffsp_pkg::SLOT_BYTES;
      pg_top_slot[pages_used] = 0;
      pg_rec_count[pages_used] = 1;
      rec_key[records_used] = key;
      rec_len[records_used] = size;
      rec_page[records_used] = pages_used;
      rec_slot[records_used] = 0;
      records_used++;
      expect_result(make_result(ffsp_pkg::ST_OK, pages_used, 0, 0, 1'b1));
      pages_used++;
    end
  endtask

  task automatic predict_search(logic [31:0] key);
    int e;
    begin
      for (int unsigned p = 0; p < pages_used; p++) begin
        e = find_record(p, key);
        if (e >= 0) begin
          expect_result(make_result(ffsp_pkg::ST_OK, p, rec_slot[e], 0, 1'b1));
          return;
        end
      end
      expect_result(make_result(ffsp_pkg::ST_NOTFOUND, 0, 0, 0, 1'b1));
    end
  endtask

  task automatic predict_display();
    int unsigned n;
    begin
      n = (pages_used > ffsp_pkg::DISPLAY_MAX) ? ffsp_pkg::DISPLAY_MAX : pages_used;
      expect_result(make_result(ffsp_pkg::ST_OK, 0, 0, pages_used, n == 0));
      for (int unsigned p = 0; p < n; p++)
        expect_result(make_result(ffsp_pkg::ST_OK, p, 0, pg_rec_count[p], p + 1 == n));
    end
  endtask

  // Drives one request, waits until the block takes it, then records what
  // it should answer. Outside a no-gap stretch each cycle idles with a
  // chance of about one in five before start goes high.
  task automatic send_request(logic [1:0] f, logic [31:0] key, logic [15:0] size);
    begin
      @(posedge clk);
      while (!no_gaps && $urandom_range(0, 99) < 19) @(posedge clk);
      start <= 1'b1;
      func <= f;
      record_key <= key;
      record_bytes <= size;
      do @(posedge clk); while (busy);
      start <= 1'b0;
      case (f)
        ffsp_pkg::FUNC_INSERT:  predict_insert(key, size);
        ffsp_pkg::FUNC_SEARCH:  predict_search(key);
        ffsp_pkg::FUNC_DISPLAY: predict_display();
        default: ;
      endcase
    end
  endtask

  // The register is only rewritten once the block has drained completely.
  task automatic write_page_bytes(logic [15:0] value);
    begin
      while (pending_results.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
      while (busy) @(posedge clk);
      @(posedge clk);
      cfg_valid <= 1'b1;
      cfg_data <= value;
      do @(posedge clk); while (!cfg_ready);
      cfg_valid <= 1'b0;
      page_bytes_q = value;
    end
  endtask

  // Random requests: keys mostly from a small pool so that replaces and
  // successful searches are common, sizes mostly small with some of full width.
  task automatic send_random_mix(int num_items, int max_small_size);
    int          pick;
    logic [1:0]  f;
    logic [31:0] key;
    logic [15:0] size;
    begin
      for (int i = 0; i < num_items; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) f = ffsp_pkg::FUNC_INSERT;
        else if (pick < 75) f = ffsp_pkg::FUNC_SEARCH;
        else if (pick < 95) f = ffsp_pkg::FUNC_DISPLAY;
        else f = FUNC_UNUSED;
        key = ($urandom_range(0, 3) != 0) ? key_pool[$urandom_range(0, 23)]
                                          : $urandom;
        size = ($urandom_range(0, 7) != 0) ? 16'($urandom_range(0, max_small_size))
                                           : 16'($urandom);
        send_request(f, key, size);
      end
    end
  endtask

  // A single key reinserted into the same page keeps taking the next slot
  // number, sent back to back with no idle cycles.
  task automatic test_slot_reuse();
    begin
      no_gaps = 1'b1;
      for (int i = 0; i < 8; i++) send_request(ffsp_pkg::FUNC_INSERT, 32'd5, 16'd0);
      no_gaps = 1'b0;
      send_request(ffsp_pkg::FUNC_SEARCH, 32'd5, 16'd0);
    end
  endtask

  task automatic test_directed();
    begin
      send_request(ffsp_pkg::FUNC_SEARCH, 32'h1234_5678, 16'd0);
      send_request(ffsp_pkg::FUNC_DISPLAY, 32'd0, 16'd0);
      send_request(FUNC_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
      send_request(ffsp_pkg::FUNC_INSERT, 32'h8000_0000, 16'd0);
      // Larger than any page: it still opens a page of its own.
      send_request(ffsp_pkg::FUNC_INSERT, 32'h7FFF_FFFF, 16'hFFFF);
      send_request(ffsp_pkg::FUNC_INSERT, 32'hFFFF_FFFF, 16'd4000);
      // The same key again in the same page replaces its size and slot.
      send_request(ffsp_pkg::FUNC_INSERT, 32'hFFFF_FFFF, 16'd10);
      send_request(ffsp_pkg::FUNC_SEARCH, 32'hFFFF_FFFF, 16'd0);
      // This key now sits in two pages; the lower one must be reported.
      send_request(ffsp_pkg::FUNC_INSERT, 32'h7FFF_FFFF, 16'd0);
      send_request(ffsp_pkg::FUNC_SEARCH, 32'h7FFF_FFFF, 16'hFFFF);
      send_request(ffsp_pkg::FUNC_SEARCH, 32'h8000_0000, 16'd0);
      send_request(ffsp_pkg::FUNC_DISPLAY, 32'hFFFF_FFFF, 16'hFFFF);
    end
  endtask

  // Smallest pages: every page takes one empty record, so the page table
  // fills up, further inserts report full, and the display runs to its widest.
  task automatic test_page_table_full();
    begin
      write_page_bytes(16'd20);
      while (pages_used < NUM_PAGES) send_request(ffsp_pkg::FUNC_INSERT, $urandom, 16'd0);
      send_request(ffsp_pkg::FUNC_INSERT, $urandom, 16'd0);
      send_request(ffsp_pkg::FUNC_INSERT, key_pool[0], 16'd3);
      send_request(ffsp_pkg::FUNC_DISPLAY, 32'd0, 16'd0);
      send_random_mix(10, 8);
    end
  endtask

  task automatic test_random_settings();
    begin
      send_random_mix(60, 300);
      write_page_bytes(16'd300);
      send_random_mix(50, 120);
      write_page_bytes(16'hFFFF);
      send_random_mix(40, 2000);
    end
  endtask

  // Every result is compared against the oldest outstanding expectation.
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      got = '{status, page_index, slot_index, count, last};
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d page %0d slot %0d count %0d last %0d",
               status, page_index, slot_index, count, last);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, got.status);
          fail_count++;
        end
        if (got.page_index !== want.page_index) begin
          $error("page_index: expected %0d, actual %0d", want.page_index,
                 got.page_index);
          fail_count++;
        end
        if (got.slot_index !== want.slot_index) begin
          $error("slot_index: expected %0d, actual %0d", want.slot_index,
                 got.slot_index);
          fail_count++;
        end
        if (got.count !== want.count) begin
          $error("count: expected %0d, actual %0d", want.count, got.count);
          fail_count++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, got.last);
          fail_count++;
        end
      end
    end
  end

  // Hang detection: any accepted request, result or register write resets
  // the count of silent cycles.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    page_bytes_q = 4096;
    pages_used = 0;
    records_used = 0;
    for (int i = 0; i < 24; i++) key_pool[i] = $urandom;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'hFFFF_FFFF;
    key_pool[3] = 32'd0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_slot_reuse();
    test_directed();
    test_random_settings();
    test_page_table_full();

    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
